[rtl/fir33_pkg.sv]
// ----------------------------------------------------------------------------
// fir33_pkg
// Types and constants for the 33-tap circular FIR filter.
// ----------------------------------------------------------------------------
package fir33_pkg;

	// stream payload widths
	localparam int IN_SAMPLE_W  = 16;
	localparam int IN_TDATA_W   = 16;
	localparam int SUM_W        = 29;
	localparam int DISP_W       = 8;
	localparam int OUT_TDATA_W  = 40;

	// coefficient file
	localparam int COEF_W       = 8;
	localparam int COEF_REGS    = 33;
	localparam int COEF_IDX_W   = $clog2(COEF_REGS);
	localparam int TAPS_PER_REG = 8;

	// display byte
	localparam int SHIFT_OUT    = 13;
	localparam int DISPLAY_BIAS = 128;

	// configuration port
	localparam int CFG_W        = 64;
	localparam int CFG_IDX_W    = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAPS_0_7   = 3'd0,
		REG_TAPS_8_15  = 3'd1,
		REG_TAPS_16_23 = 3'd2,
		REG_TAPS_24_31 = 3'd3,
		REG_TAP_32     = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

endpackage

[rtl/fir_filter_circular_33tap_unit.sv]
// ----------------------------------------------------------------------------
// fir_filter_circular_33tap_unit
// Integer FIR filter over a circular delay line held in a synchronous memory,
// one shared multiply-accumulate stepping through the taps for each sample.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                  | handshake
//  s_*       | in  | tdata: sample[15:0]                      | tvalid/tready
//  m_*       | out | tdata: filtered_sum[28:0], display[36:29]| tvalid/tready
//  cfg_*     | in  | cfg_index selects register, cfg_data     | cfg_we, no wait
//
//  each sample passes through accept, TAPS delay line reads through the
//  single read port of the sample memory, an accumulate drain, an output load.
//  reset clears the coefficients, the write position and the per-entry valid
//  bits; an entry never written since reset reads as zero.
//  a finished word waits in the output register; the next sample is accepted
//  meanwhile, and only the output load stalls until that word is taken.
// ----------------------------------------------------------------------------
module fir_filter_circular_33tap_unit #(
	parameter int TAPS        = 33,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample[15:0]
	input  logic [fir33_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// filtered_sum[28:0], display_byte[36:29], zero fill[39:37]
	output logic [fir33_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic                                 cfg_we,
	input  logic [fir33_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fir33_pkg::CFG_W-1:0]          cfg_data
);
	import fir33_pkg::*;

	localparam int AW    = $clog2(TAPS);
	localparam int PROD_W = SAMPLE_BITS + COEF_W;
	localparam int ACC_W  = PROD_W + $clog2(COEF_REGS) + 1;
	localparam int EXT_W  = (ACC_W > SUM_W) ? ACC_W : SUM_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);

	state_t state_q;

	// coefficient registers
	logic signed [COEF_W-1:0] coef_q [COEF_REGS];

	// delay line memory and its valid bits
	logic [SAMPLE_BITS-1:0] mem [TAPS];
	logic [TAPS-1:0]        valid_q;

	logic [AW-1:0] pos_q;
	logic [AW-1:0] rd_addr_q;
	logic [AW-1:0] cnt_q;

	// read / multiply stage
	logic [SAMPLE_BITS-1:0]   rd_data_s1;
	logic                     rd_valid_s1;
	logic                     rd_vld_s1;
	logic signed [COEF_W-1:0] coef_s1;

	logic signed [ACC_W-1:0]  acc_q;
	logic [SUM_W-1:0]         sum_q;
	logic [DISP_W-1:0]        disp_q;
	logic                     m_tvalid_q;

	logic                     in_acc;
	logic                     out_load;
	logic signed [IN_SAMPLE_W-1:0] in_sample;
	logic signed [SAMPLE_BITS-1:0] new_sample;
	logic signed [SAMPLE_BITS-1:0] tap_sample;
	logic signed [PROD_W-1:0]      prod;
	logic signed [EXT_W-1:0]       acc_ext;
	logic signed [COEF_W-1:0]      coef_sel;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_load  = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	assign in_sample  = s_tdata[IN_SAMPLE_W-1:0];
	assign new_sample = SAMPLE_BITS'(in_sample);

	// taps beyond the coefficient file weigh zero
	assign coef_sel = (32'(cnt_q) < COEF_REGS) ? coef_q[COEF_IDX_W'(cnt_q)] : '0;

	assign tap_sample = rd_valid_s1 ? $signed(rd_data_s1) : '0;
	assign prod       = tap_sample * coef_s1;
	assign acc_ext    = EXT_W'(acc_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			rd_addr_q <= '0;
			cnt_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						rd_addr_q <= pos_q;
						cnt_q     <= '0;
						pos_q     <= (pos_q == '0) ? LAST_ADDR : pos_q - 1'b1;
						state_q   <= ST_RUN;
					end
				end
				ST_RUN: begin
					rd_addr_q <= (rd_addr_q == LAST_ADDR) ? '0 : rd_addr_q + 1'b1;
					cnt_q     <= cnt_q + 1'b1;
					if (cnt_q == LAST_ADDR) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sample memory: write on accept, one registered read per cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mem[pos_q] <= new_sample;
		end
		rd_data_s1 <= mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_q[pos_q] <= 1'b1;
			end
			rd_valid_s1 <= valid_q[rd_addr_q];
			rd_vld_s1   <= (state_q == ST_RUN);
		end
	end

	always_ff @(posedge clk) begin
		coef_s1 <= coef_sel;
	end

	// multiply-accumulate
	always_ff @(posedge clk) begin
		if (in_acc) begin
			acc_q <= '0;
		end else if (rd_vld_s1) begin
			acc_q <= acc_q + ACC_W'(prod);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			sum_q  <= acc_ext[SUM_W-1:0];
			disp_q <= acc_q[SHIFT_OUT +: DISP_W] + DISP_W'(DISPLAY_BIAS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_TDATA_W - SUM_W - DISP_W)'(0), disp_q, sum_q};

	// coefficient writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_REGS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				REG_TAPS_0_7, REG_TAPS_8_15, REG_TAPS_16_23, REG_TAPS_24_31: begin
					for (int k = 0; k < TAPS_PER_REG; k++) begin
						coef_q[COEF_IDX_W'({cfg_index[1:0], 3'(k)})] <= cfg_data[COEF_W*k +: COEF_W];
					end
				end
				REG_TAP_32: begin
					coef_q[COEF_REGS-1] <= cfg_data[COEF_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// assertions
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_RUN) && (cnt_q == '0) && (acc_q == '0))
		else $error("accept did not start a clean pass");

	a_pos_steps_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (pos_q == (($past(pos_q) == '0) ? LAST_ADDR : $past(pos_q) - 1'b1)))
		else $error("write position did not step back by one");

	a_last_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && (cnt_q == LAST_ADDR) |=> (state_q == ST_WAIT) && rd_vld_s1)
		else $error("last tap read not followed by drain");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_FIN))
		else $error("output word loaded outside the final state");

endmodule
